### src/ipc_pkg.sv
// ============================================================================
// Isolated pixel checker package
// Shared sizes, register indexes and line store layout.
// ============================================================================
package ipc_pkg;

    // Largest frame that the line store and the counters cover.
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    // Size registers as written over the configuration port.
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Width in which a size register is clamped and compared.
    localparam int COL_CW = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
    localparam int ROW_CW = (CFG_W > ROW_W + 1) ? CFG_W : ROW_W + 1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 1'b1;

    // Line store entry: pixel of the row above, and its pending mark.
    localparam int LS_W     = 2;
    localparam int PIX_BIT  = 0;
    localparam int PEND_BIT = 1;

    // One pixel on its way from the accept stage to the judging stage.
    typedef struct packed {
        logic             pix;
        logic             prev;
        logic             prev2;
        logic [COL_W-1:0] col;
        logic             have_up;
        logic             last_row;
        logic             last_col;
        logic             col_nz;
        logic             col_ge2;
        logic             single;
    } t_s1;

endpackage

### src/ipc_ram.sv
// ============================================================================
// Generic single port pair RAM
// One write port and one read port with registered read data.
// ============================================================================
module ipc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/isolated_pixel_checker.sv
// ============================================================================
// Isolated pixel checker
// Checks a binary raster frame for set pixels with no set four-neighbour
// and gives one verdict word per frame.
// ============================================================================
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  ----------------------
//  in        to block   i_in_valid / o_in_stall    i_pixel_set
//  out       from block o_out_valid / i_out_stall  o_all_connected
//  cfg       to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  The block takes one pixel word per cycle while o_in_stall is low; the
//  rate is set by the single read-modify-write of the line store RAM that
//  each pixel makes. Each pixel passes the accept stage, which issues the
//  line store read, and then the judging stage, which judges the pixel and
//  writes back. The verdict word is loaded into the output register at the
//  end of the judging stage, so it is offered once the last pixel word of
//  the frame has passed that stage. After reset a clearing pass writes
//  zeros to all MAX_COLS line store entries, with o_in_stall held high;
//  configuration writes are taken throughout.
//  o_in_stall otherwise rises only when a verdict is ready while the
//  previous verdict is still stalled in the output register.
//
// ============================================================================
module isolated_pixel_checker
    import ipc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_pixel_set,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_all_connected,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // ------------------------------------------------------------------------
    // Configuration registers. The port never pushes back.
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] r_frame_rows;
    logic [CFG_W-1:0] r_frame_cols;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= CFG_W'(1);
            r_frame_cols <= CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAME_ROWS: r_frame_rows <= i_cfg_data;
                CFG_FRAME_COLS: r_frame_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A size of zero acts as one, and a size above the line store acts as
    // the largest size.
    logic [ROW_CW-1:0] frame_h;
    logic [COL_CW-1:0] frame_w;
    logic [ROW_CW-1:0] rows_cfg;
    logic [COL_CW-1:0] cols_cfg;

    assign rows_cfg = ROW_CW'(r_frame_rows);
    assign cols_cfg = COL_CW'(r_frame_cols);

    always_comb begin
        if (rows_cfg == '0) begin
            frame_h = ROW_CW'(1);
        end else if (rows_cfg > ROW_CW'(MAX_ROWS)) begin
            frame_h = ROW_CW'(MAX_ROWS);
        end else begin
            frame_h = rows_cfg;
        end
        if (cols_cfg == '0) begin
            frame_w = COL_CW'(1);
        end else if (cols_cfg > COL_CW'(MAX_COLS)) begin
            frame_w = COL_CW'(MAX_COLS);
        end else begin
            frame_w = cols_cfg;
        end
    end

    // ------------------------------------------------------------------------
    // Clearing pass after reset: one line store entry per cycle.
    // ------------------------------------------------------------------------
    logic             r_clr_busy;
    logic [COL_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + COL_W'(1);
            if (r_clr_addr == COL_W'(MAX_COLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Handshake control.
    // ------------------------------------------------------------------------
    logic r_s1_valid;
    t_s1  r_s1;
    logic r_out_valid;
    logic r_all_connected;
    logic s1_hold;
    logic s1_go;
    logic in_accept;
    logic s1_end;

    // The judging stage waits only when it has a verdict and the output
    // register is still holding the previous one.
    assign s1_end     = r_s1.last_row && r_s1.last_col;
    assign s1_hold    = r_s1_valid && s1_end && r_out_valid && i_out_stall;
    assign s1_go      = r_s1_valid && !s1_hold;
    assign o_in_stall = r_clr_busy || s1_hold;
    assign in_accept  = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------------
    // Accept stage: position counters and the two latest pixels of the row.
    // ------------------------------------------------------------------------
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [1:0]       r_recent;
    logic             last_row;
    logic             last_col;
    t_s1              n_s1;

    // A counter at or past the last row or column counts as on it, so a
    // frame that shrinks in the middle still ends.
    assign last_row = ROW_CW'(r_row) >= (frame_h - ROW_CW'(1));
    assign last_col = COL_CW'(r_col) >= (frame_w - COL_CW'(1));

    always_comb begin
        n_s1.pix      = i_pixel_set;
        n_s1.prev     = r_recent[0];
        n_s1.prev2    = r_recent[1];
        n_s1.col      = r_col;
        n_s1.have_up  = (r_row != '0);
        n_s1.last_row = last_row;
        n_s1.last_col = last_col;
        n_s1.col_nz   = (r_col != '0);
        n_s1.col_ge2  = (r_col > COL_W'(1));
        n_s1.single   = (frame_h == ROW_CW'(1)) && (frame_w == COL_CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_recent <= '0;
        end else if (in_accept) begin
            if (last_col) begin
                r_col    <= '0;
                r_recent <= '0;
                if (last_row) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + ROW_W'(1);
                end
            end else begin
                r_col    <= r_col + COL_W'(1);
                r_recent <= {r_recent[0], i_pixel_set};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept || s1_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= n_s1;
        end
    end

    // ------------------------------------------------------------------------
    // Line store and its write port.
    // ------------------------------------------------------------------------
    // A pixel that is last in its row writes two entries: the one to its
    // left now, and its own entry in the next cycle from r_dw_data. The pixel
    // after it is the first of a row and writes nothing, so the port is always free.
    logic             we;
    logic [COL_W-1:0] waddr;
    logic [LS_W-1:0]  wdata;
    logic [LS_W-1:0]  ram_rdata;
    logic             s1_wr;
    logic [LS_W-1:0]  s1_wdata;
    logic             r_dw_valid;
    logic [COL_W-1:0] r_dw_addr;
    logic [LS_W-1:0]  r_dw_data;
    logic [LS_W-1:0]  dw_data;

    always_comb begin
        if (r_clr_busy) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = '0;
        end else if (s1_wr) begin
            we    = 1'b1;
            waddr = r_s1.col - COL_W'(1);
            wdata = s1_wdata;
        end else begin
            we    = r_dw_valid;
            waddr = r_dw_addr;
            wdata = r_dw_data;
        end
    end

    ipc_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_COLS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Forwarding: a write to the entry held in the judging stage that lands
    // on or after the read edge replaces the RAM data. The delayed write of a
    // row's last pixel, which lands at the end of the judging cycle, is taken
    // straight from its register; this matters for one pixel wide frames.
    logic             r_fwd_valid;
    logic [LS_W-1:0]  r_fwd_data;
    logic [COL_W-1:0] n_s1_col;
    logic [LS_W-1:0]  eff;

    assign n_s1_col = in_accept ? r_col : r_s1.col;
    assign eff      = (r_dw_valid && (r_dw_addr == r_s1.col)) ? r_dw_data :
                      r_fwd_valid ? r_fwd_data : ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (we && (waddr == n_s1_col)) begin
            r_fwd_valid <= 1'b1;
        end else if (in_accept) begin
            r_fwd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we && (waddr == n_s1_col)) begin
            r_fwd_data <= wdata;
        end
    end

    // ------------------------------------------------------------------------
    // Judging stage.
    // ------------------------------------------------------------------------
    // The pixel to the left now has its right neighbour. Its upper neighbour
    // was read with the previous pixel and kept in r_up_prev. A set pixel
    // with no neighbour yet is marked pending; in the last row it fails.
    logic r_up_prev;
    logic r_fail;
    logic up_l;
    logic none_l;
    logic pend_l;
    logic fail_l;
    logic up_c;
    logic none_c;
    logic pend_c;
    logic fail_c;
    logic fail_u;
    logic fail_next;

    always_comb begin
        up_l   = r_s1.have_up && r_up_prev;
        none_l = !(up_l || (r_s1.col_ge2 && r_s1.prev2) || r_s1.pix);
        pend_l = r_s1.prev && none_l && !r_s1.last_row;
        fail_l = r_s1.col_nz && r_s1.prev && none_l && r_s1.last_row;

        // The last pixel of a row has no right neighbour inside the frame.
        up_c   = r_s1.have_up && eff[PIX_BIT];
        none_c = !(up_c || (r_s1.col_nz && r_s1.prev));
        pend_c = r_s1.pix && none_c && !r_s1.last_row;
        fail_c = r_s1.last_col && r_s1.pix && none_c && r_s1.last_row;

        // A pending pixel above is settled by the pixel under it.
        fail_u = r_s1.have_up && eff[PEND_BIT] && !r_s1.pix;

        fail_next = r_fail || fail_l || fail_c || fail_u;
    end

    assign s1_wr = s1_go && r_s1.col_nz;

    always_comb begin
        s1_wdata           = '0;
        s1_wdata[PIX_BIT]  = r_s1.prev;
        s1_wdata[PEND_BIT] = pend_l;
        dw_data            = '0;
        dw_data[PIX_BIT]   = r_s1.pix;
        dw_data[PEND_BIT]  = pend_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dw_valid <= 1'b0;
            r_fail     <= 1'b0;
        end else begin
            r_dw_valid <= s1_go && r_s1.last_col;
            if (s1_go) begin
                r_fail <= s1_end ? 1'b0 : fail_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_up_prev <= eff[PIX_BIT];
            r_dw_addr <= r_s1.col;
            r_dw_data <= dw_data;
        end
    end

    // ------------------------------------------------------------------------
    // Output register. A one by one frame never passes.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_end) begin
            r_all_connected <= !fail_next && !r_s1.single;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_all_connected = r_all_connected;

endmodule

### src/ipc_checker.sv
// ============================================================================
// Isolated pixel checker port checker
// Assertions on the top level ports, attached by a bind statement.
// ============================================================================
module ipc_checker
    import ipc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_all_connected
);

    // A stalled verdict word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("verdict word dropped while stalled");

    // A stalled verdict word keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_all_connected))
        else $error("verdict word changed while stalled");

    // The line store clearing pass keeps the pixel input closed after reset.
    a_clear_stall: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_stall)
        else $error("pixel input open before line store is cleared");

    // A fresh verdict follows an accepted pixel word that passed r_s1 and then the output register.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("verdict word without a preceding pixel word");

endmodule

bind isolated_pixel_checker ipc_checker u_ipc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_all_connected (o_all_connected)
);

### test/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// Isolated pixel checker testbench
// Streams binary frames of many sizes through the checker, works out the
// verdict of every frame with a software copy of the judging rules and
// compares each verdict word that leaves the block against it.
// ============================================================================
module tb_top;
    import ipc_pkg::*;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 i_pixel_set = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_all_connected;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_FRAME_ROWS;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    isolated_pixel_checker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pixel_set     (i_pixel_set),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_all_connected (o_all_connected),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 10 ns clock period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Software copy of the checker state. It advances once per accepted pixel
    // word, so it always describes the frame position of the next pixel.
    // ------------------------------------------------------------------------
    logic [LS_W-1:0]  shadow_line [MAX_COLS];
    int unsigned      shadow_row;
    int unsigned      shadow_col;
    logic [1:0]       shadow_recent;
    logic             shadow_isolated;
    logic [CFG_W-1:0] rows_reg = CFG_W'(1);
    logic [CFG_W-1:0] cols_reg = CFG_W'(1);

    // Pixels waiting to be sent, and verdicts waiting to come out.
    logic        pixel_q [$];
    logic        verdicts_q [$];

    // Idling rates in percent, changed by the stimulus as the run goes on.
    int unsigned send_idle_pct  = 17;
    int unsigned recv_stall_pct = 61;
    int unsigned mismatch_count = 0;

    // A size register of zero means one; anything above the line store or
    // row counter range is cut down to that range.
    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned lim);
        if (v == '0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic int unsigned frame_h();
        return clamp_dim(rows_reg, MAX_ROWS);
    endfunction

    function automatic int unsigned frame_w();
        return clamp_dim(cols_reg, MAX_COLS);
    endfunction

    // Judges one pixel once its left, upper and right neighbours are known.
    // A lone set pixel in the last row fails at once; elsewhere it is left
    // pending in the line store for the pixel below to settle.
    function automatic void settle_column(int unsigned col, logic pix, logic up,
                                          logic left, logic right, logic last_row);
        logic pend;
        pend = pix && !(up || left || right);
        if (pend && last_row) begin
            shadow_isolated = 1'b1;
            pend = 1'b0;
        end
        shadow_line[col][PIX_BIT]  = pix;
        shadow_line[col][PEND_BIT] = pend;
    endfunction

    // Takes one pixel word and tells whether it closes a frame, and with
    // which verdict.
    function automatic void judge_pixel(input logic pix, output logic done,
                                        output logic verdict);
        int unsigned h;
        int unsigned w;
        int unsigned r;
        int unsigned c;
        logic        have_up;
        logic        last_row;
        logic        last_col;
        logic        prev;
        logic        prev2;
        h        = frame_h();
        w        = frame_w();
        r        = shadow_row;
        c        = shadow_col;
        // Row 0 never looks at the line store, so leftovers of an earlier
        // frame cannot matter. Counters past a shrunken size count as being
        // on the last row or column.
        have_up  = (r > 0);
        last_row = (r >= h - 1);
        last_col = (c >= w - 1);
        prev     = shadow_recent[0];
        prev2    = shadow_recent[1];
        done     = 1'b0;
        verdict  = 1'b0;

        // A pending pixel above is rescued only by a set pixel below it.
        if (have_up && shadow_line[c][PEND_BIT] && !pix)
            shadow_isolated = 1'b1;
        // The previous pixel of this row now has its right neighbour.
        if (c > 0)
            settle_column(c - 1, prev, have_up && shadow_line[c - 1][PIX_BIT],
                          (c >= 2) && prev2, pix, last_row);
        // The last pixel of a row has nothing to its right.
        if (last_col)
            settle_column(c, pix, have_up && shadow_line[c][PIX_BIT],
                          (c > 0) && prev, 1'b0, last_row);

        shadow_recent = {prev, pix};
        if (last_col) begin
            shadow_col    = 0;
            shadow_recent = 2'b00;
            if (last_row) begin
                done            = 1'b1;
                // A one pixel frame never passes.
                verdict         = !shadow_isolated && !(h == 1 && w == 1);
                shadow_row      = 0;
                shadow_isolated = 1'b0;
            end else begin
                shadow_row = r + 1;
            end
        end else begin
            shadow_col = c + 1;
        end
    endfunction

    // Number of pixels that close the frame in progress under the present
    // sizes; a whole frame when the block stands at the start of one.
    function automatic int unsigned pixels_to_frame_end();
        int unsigned h;
        int unsigned w;
        int unsigned n;
        h = frame_h();
        w = frame_w();
        n = (shadow_col >= w - 1) ? 1 : w - shadow_col;
        if (shadow_row < h - 1)
            n += (h - 1 - shadow_row) * w;
        return n;
    endfunction

    // Share of set pixels in a frame. Sparse frames fail almost surely,
    // dense and full ones mostly pass, empty ones pass unless one pixel big.
    function automatic int unsigned pick_density();
        case ($urandom_range(4))
            0: return 0;
            1: return 15;
            2: return 50;
            3: return 85;
            default: return 100;
        endcase
    endfunction

    task automatic push_pixels(input int unsigned n, input int unsigned set_pct);
        for (int unsigned i = 0; i < n; i++)
            pixel_q.insert(pixel_q.size(), ($urandom_range(99) < set_pct));
    endtask

    // Pushes the n lowest bits of a pattern, leftmost first.
    task automatic push_pattern(input logic [31:0] bits, input int n);
        for (int i = n - 1; i >= 0; i--)
            pixel_q.insert(pixel_q.size(), bits[i]);
    endtask

    // Completes the frame in progress with random content. Only called when
    // the block is idle, so the software state matches the block.
    task automatic finish_frame(output int unsigned n);
        n = pixels_to_frame_end();
        push_pixels(n, pick_density());
    endtask

    // Waits until no pixel word is pending or on the bus and no verdict word
    // is due or offered, and the quiet counter of such cycles has run out, so
    // that the pixels still inside the block have drained as well.
    task automatic wait_idle();
        int unsigned quiet;
        quiet = 0;
        while (quiet < 8) begin
            @(posedge i_clk);
            if (pixel_q.size() != 0 || i_in_valid || o_out_valid ||
                verdicts_q.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_ROWS)
            rows_reg = val;
        else
            cols_reg = val;
    endtask

    // ------------------------------------------------------------------------
    // Driver. A pixel word stays on the bus while stalled; a new one is loaded
    // only after the previous one was taken, unless the sender idles.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || !o_in_stall) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid  <= 1'b1;
                    i_pixel_set <= pixel_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Both channels are observed in one process, so an expected
    // verdict is always queued before the word it predicts can be checked.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        logic done;
        logic verdict;
        logic want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                judge_pixel(i_pixel_set, done, verdict);
                if (done)
                    verdicts_q.insert(verdicts_q.size(), verdict);
            end
            if (o_out_valid && !i_out_stall) begin
                if (verdicts_q.size() == 0) begin
                    $error("all_connected: no verdict expected, got %0d", o_all_connected);
                    mismatch_count++;
                end else begin
                    want = verdicts_q.pop_front();
                    if (o_all_connected !== want) begin
                        $error("all_connected: expected %0d, got %0d", want, o_all_connected);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. A short directed part, then random phases of small frames,
    // then the largest frame shapes. Sizes change only while the block is
    // idle, sometimes in the middle of a frame.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned random_items;
        int unsigned frames_done;
        int unsigned n;
        int unsigned area;

        for (int i = 0; i < MAX_COLS; i++)
            shadow_line[i] = '0;
        shadow_row      = 0;
        shadow_col      = 0;
        shadow_recent   = 2'b00;
        shadow_isolated = 1'b0;
        random_items    = 0;
        frames_done     = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sizes after reset describe a one pixel frame, which always fails,
        // set or clear.
        push_pattern(32'b10, 2);
        wait_idle();

        // Zero in both registers is read as one.
        write_reg(CFG_FRAME_ROWS, '0);
        write_reg(CFG_FRAME_COLS, '0);
        push_pattern(32'b1, 1);
        wait_idle();

        // Two by three frames: a lone pixel left pending in the top row, a
        // vertical pair that passes, and a lone pixel in the last row.
        write_reg(CFG_FRAME_ROWS, CFG_W'(2));
        write_reg(CFG_FRAME_COLS, CFG_W'(3));
        push_pattern(32'b010_000, 6);
        push_pattern(32'b010_010, 6);
        push_pattern(32'b000_010, 6);
        wait_idle();

        // Stop inside a three by three frame, then shrink it to two by two.
        // The counters now sit on the last row and column, so the next pixel
        // closes the frame.
        write_reg(CFG_FRAME_ROWS, CFG_W'(3));
        push_pattern(32'b110_1, 4);
        wait_idle();
        write_reg(CFG_FRAME_ROWS, CFG_W'(2));
        write_reg(CFG_FRAME_COLS, CFG_W'(2));
        push_pattern(32'b0, 1);

        // Random phases: new sizes, the rest of the current frame, a few
        // whole frames and now and then a frame cut short.
        while (random_items < 700 || frames_done < 40) begin
            if (random_items < 240) begin
                send_idle_pct  = 17;
                recv_stall_pct = 61;
            end else if (random_items < 480) begin
                send_idle_pct  = 61;
                recv_stall_pct = 17;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            wait_idle();
            if ($urandom_range(2) != 1)
                write_reg(CFG_FRAME_ROWS, ($urandom_range(9) == 0) ? '0 :
                          CFG_W'($urandom_range(6, 1)));
            if ($urandom_range(2) != 0)
                write_reg(CFG_FRAME_COLS, ($urandom_range(9) == 0) ? '0 :
                          ($urandom_range(3) == 0) ? CFG_W'($urandom_range(40, 7)) :
                          CFG_W'($urandom_range(6, 1)));
            finish_frame(n);
            random_items += n;
            frames_done++;
            area = frame_h() * frame_w();
            repeat ($urandom_range(2)) begin
                push_pixels(area, pick_density());
                random_items += area;
                frames_done++;
            end
            if ($urandom_range(5) == 0 && area > 1) begin
                n = $urandom_range(area - 1, 1);
                push_pixels(n, pick_density());
                random_items += n;
            end
        end

        // Largest shapes: an all-ones register clamps to the maximum. A long
        // one pixel wide column is started and then closed early by shrinking
        // the row count, then a long row is started and closed by shrinking
        // the column count.
        wait_idle();
        write_reg(CFG_FRAME_ROWS, {CFG_W{1'b1}});
        write_reg(CFG_FRAME_COLS, CFG_W'(1));
        push_pixels(24, pick_density());
        wait_idle();
        write_reg(CFG_FRAME_ROWS, CFG_W'(1));
        finish_frame(n);
        wait_idle();
        write_reg(CFG_FRAME_ROWS, CFG_W'(2));
        write_reg(CFG_FRAME_COLS, {CFG_W{1'b1}});
        push_pixels(20, pick_density());
        wait_idle();
        write_reg(CFG_FRAME_COLS, CFG_W'(3));
        finish_frame(n);
        wait_idle();

        // Extra quiet time so that a stray verdict word is still caught.
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("isolated_pixel_checker: match");
        else
            $display("isolated_pixel_checker: mismatch");
        $finish;
    end

    // Ends a run that hangs, far beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("isolated_pixel_checker: mismatch");
        $finish;
    end

endmodule
